/* src/msfb_pkg.sv */
// ----------------------------------------------------------------------------
// msfb_pkg - shared types and constants for the motor speed frame builder
// Request payloads, sequencer states, multiplier and shadow-frame interfaces.
// ----------------------------------------------------------------------------
package msfb_pkg;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam logic REG_LIMIT_HIGH = 1'b0;
  localparam logic REG_LIMIT_LOW  = 1'b1;
  localparam logic signed [15:0] LIMIT_HIGH_RST = 16'sd327;
  localparam logic signed [15:0] LIMIT_LOW_RST  = -16'sd327;

  // Speed unit codes
  localparam logic [1:0] ACT_RPM  = 2'd0;
  localparam logic [1:0] ACT_RPS  = 2'd1;
  localparam logic [1:0] ACT_RADS = 2'd2;

  // Frame identifiers
  localparam logic [5:0] IDENT_GROUP_A = 6'd50;
  localparam logic [5:0] IDENT_GROUP_B = 6'd51;

  // Shared multiplier operand widths and factors
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] RPS_FACTOR      = 20'd60;
  localparam logic [MUL_B_W-1:0] RADS_FACTOR_Q16 = 20'd625823;
  localparam logic [MUL_B_W-1:0] SPEED_SCALE     = 20'd100;

  // Protocol saturation magnitude
  localparam logic [14:0] PROTO_MAX = 15'd32767;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         motor_id;
    logic signed [31:0] speed_value;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        frame_valid;
    logic [5:0]  frame_ident;
    logic [31:0] payload_high;
    logic [31:0] payload_low;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_CLAMP,
    S_SCALE,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        en;
    logic        grp;
    logic [1:0]  slot;
    logic [15:0] word;
  } shadow_wr_t;

endpackage

/* src/msfb_mul.sv */
// ----------------------------------------------------------------------------
// msfb_mul - shared unsigned multiplier
// One registered 32x20 product, loaded when the sequencer enables it.
// ----------------------------------------------------------------------------
module msfb_mul (
  input  logic                      clk,
  input  msfb_pkg::mul_req_t        req,
  output logic [msfb_pkg::MUL_P_W-1:0] prod
);
  import msfb_pkg::*;

  // product register, held while the unit is not in use
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
    end
  end

endmodule

/* src/msfb_shadow.sv */
// ----------------------------------------------------------------------------
// msfb_shadow - shadow group frames
// Two 64-bit frames; one 16-bit slot is replaced per write request.
// ----------------------------------------------------------------------------
module msfb_shadow (
  input  logic                 clk,
  input  logic                 rst,
  input  msfb_pkg::shadow_wr_t wr,
  output logic [63:0]          new_frame
);
  import msfb_pkg::*;

  logic [63:0] frames [2];
  logic [63:0] old_frame;

  // merge the new word into the selected slot, slot 0 in the top bits
  always_comb begin
    old_frame = frames[wr.grp];
    new_frame = old_frame;
    case (wr.slot)
      2'd0:    new_frame[63:48] = wr.word;
      2'd1:    new_frame[47:32] = wr.word;
      2'd2:    new_frame[31:16] = wr.word;
      default: new_frame[15:0]  = wr.word;
    endcase
  end

  // frame store, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      frames[0] <= '0;
      frames[1] <= '0;
    end else if (wr.en) begin
      frames[wr.grp] <= new_frame;
    end
  end

endmodule

/* src/motor_speed_frame_builder.sv */
// ----------------------------------------------------------------------------
// motor_speed_frame_builder - speed command to group frame converter
// Converts one speed command into rpm, clamps and scales it, and emits the
// updated 8-byte group frame, or a status flag for an out-of-range motor id.
// ----------------------------------------------------------------------------
// A request for a valid motor passes through these steps in order: accept,
// conversion multiply, round and clamp, scale multiply, frame update. A request
// with an out-of-range motor id goes straight from accept to the frame step.
// All multiplication goes through one shared 32x20 multiplier with a registered
// product. in_ready is high only while the sequencer is idle; a finished frame
// sits in an output register, so a new request may be taken while it waits,
// and the sequencer holds in its last step only if the previous frame has
// not yet been taken.
module motor_speed_frame_builder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  msfb_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output msfb_pkg::out_item_t                 out_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [msfb_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import msfb_pkg::*;

  state_t state, state_next;

  logic signed [15:0] limit_high, limit_low;
  in_item_t           item;
  logic               bad_id;
  logic signed [15:0] rpm, rpm_next;
  logic [MUL_P_W-1:0] prod;
  mul_req_t           mul_req;
  shadow_wr_t         shadow_wr;
  logic [63:0]        new_frame;
  logic               out_free;
  logic               out_load;
  out_item_t          out_item_next;

  // conversion helpers
  logic               raw_neg;
  logic [31:0]        raw_mag;
  logic [MUL_P_W:0]   round_sum;
  logic [MUL_P_W-16:0] conv_mag;
  logic signed [15:0] conv_rpm;
  logic signed [16:0] rpm_wide;
  logic [16:0]        rpm_mag;
  logic [14:0]        scaled_mag;
  logic [15:0]        scaled;
  logic [7:0]         id_m1;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // register read
  always_comb begin
    if (paddr[2] == REG_LIMIT_LOW) begin
      prdata = 32'(limit_low);
    end else begin
      prdata = 32'(limit_high);
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_high <= LIMIT_HIGH_RST;
      limit_low  <= LIMIT_LOW_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_LIMIT_HIGH) begin
        limit_high <= pwdata[15:0];
      end else begin
        limit_low <= pwdata[15:0];
      end
    end
  end

  // magnitude of the raw speed; the most negative value keeps its bit pattern
  assign raw_neg = item.speed_value[31];
  assign raw_mag = raw_neg ? (~item.speed_value + 32'd1) : item.speed_value;

  // round half away from zero on the magnitude, then restore sign and saturate
  always_comb begin
    if (item.action == ACT_RADS) begin
      round_sum = {1'b0, prod} + (MUL_P_W+1)'(33'h0_8000_0000);
      conv_mag  = (MUL_P_W-15)'(round_sum[MUL_P_W:32]);
    end else begin
      round_sum = {1'b0, prod} + (MUL_P_W+1)'(17'h0_8000);
      conv_mag  = round_sum[MUL_P_W:16];
    end
    if (raw_neg) begin
      conv_rpm = (conv_mag >= (MUL_P_W-15)'(32768)) ? 16'sh8000 : -$signed(conv_mag[15:0]);
    end else begin
      conv_rpm = (conv_mag >= (MUL_P_W-15)'(32767)) ? 16'sh7fff : $signed(conv_mag[15:0]);
    end
  end

  // unit selection, int16 saturation for plain rpm, then limit clamp
  always_comb begin
    rpm_next = conv_rpm;
    if (item.action != ACT_RPS && item.action != ACT_RADS) begin
      if (item.speed_value > 32'sd32767) begin
        rpm_next = 16'sh7fff;
      end else if (item.speed_value < -32'sd32768) begin
        rpm_next = 16'sh8000;
      end else begin
        rpm_next = item.speed_value[15:0];
      end
    end
    if (rpm_next > limit_high) begin
      rpm_next = limit_high;
    end else if (rpm_next < limit_low) begin
      rpm_next = limit_low;
    end
  end

  // magnitude for the scale step and protocol saturation of the result
  assign rpm_wide   = 17'(rpm);
  assign rpm_mag    = rpm[15] ? 17'(-rpm_wide) : 17'(rpm_wide);
  assign scaled_mag = (prod > MUL_P_W'(PROTO_MAX)) ? PROTO_MAX : prod[14:0];
  assign scaled     = rpm[15] ? (16'd0 - {1'b0, scaled_mag}) : {1'b0, scaled_mag};
  assign id_m1      = item.motor_id - 8'd1;

  // shared multiplier
  msfb_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // shadow frames
  msfb_shadow u_shadow (
    .clk       (clk),
    .rst       (rst),
    .wr        (shadow_wr),
    .new_frame (new_frame)
  );

  // sequencer: next state and unit controls
  always_comb begin
    state_next    = state;
    mul_req       = '0;
    out_load      = 1'b0;
    out_item_next = '0;
    shadow_wr.en   = 1'b0;
    shadow_wr.grp  = id_m1[2];
    shadow_wr.slot = id_m1[1:0];
    shadow_wr.word = scaled;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_item.motor_id < 8'd1 || in_item.motor_id > 8'd8) ?
                       S_WRITE : S_CONV;
        end
      end
      S_CONV: begin
        mul_req.en = 1'b1;
        mul_req.a  = raw_mag;
        case (item.action)
          ACT_RPS:  mul_req.b = RPS_FACTOR;
          ACT_RADS: mul_req.b = RADS_FACTOR_Q16;
          default:  mul_req.b = '0;
        endcase
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        state_next = S_SCALE;
      end
      S_SCALE: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(rpm_mag);
        mul_req.b  = SPEED_SCALE;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (bad_id) begin
            out_item_next.status = 1'b1;
          end else begin
            shadow_wr.en               = 1'b1;
            out_item_next.frame_valid  = 1'b1;
            out_item_next.frame_ident  = id_m1[2] ? IDENT_GROUP_B : IDENT_GROUP_A;
            out_item_next.payload_high = new_frame[63:32];
            out_item_next.payload_low  = new_frame[31:0];
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item   <= in_item;
      bad_id <= (in_item.motor_id < 8'd1 || in_item.motor_id > 8'd8);
    end
    if (state == S_CLAMP) begin
      rpm <= rpm_next;
    end
    if (out_load) begin
      out_item <= out_item_next;
    end
  end

  // a shadow frame update always produces a waiting result
  a_write_gives_result: assert property (@(posedge clk) disable iff (rst)
    shadow_wr.en |=> out_valid && out_item.frame_valid)
    else $error("frame update without result");

  // the sequencer takes no further request while one is at work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // an emitted frame carries one of the two group identifiers
  a_frame_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_valid |->
      out_item.frame_ident == IDENT_GROUP_A || out_item.frame_ident == IDENT_GROUP_B)
    else $error("bad frame identifier");

endmodule
